### hw/rtl/lsm_pkg.sv
`timescale 1ns / 1ps

package lsm_pkg;

  // Field widths of the channels.
  localparam int CHAR_W        = 8;
  localparam int LINE_NUMBER_W = 20;
  localparam int LINE_LENGTH_W = 12;
  localparam int CFG_INDEX_W   = 3;
  localparam int CFG_DATA_W    = 64;

  // Defaults for the top-level parameters.
  localparam int PATTERN_MAX_DEF      = 32;
  localparam int LINE_MAX_DEF         = 4096;
  localparam int LINE_NUMBER_BITS_DEF = 20;

  // Character codes.
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [CHAR_W-1:0] UPPER_A_CHAR = 8'h41;
  localparam logic [CHAR_W-1:0] UPPER_Z_CHAR = 8'h5A;
  localparam logic [CHAR_W-1:0] CASE_BIT     = 8'h20;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_0   = 3'd0,
    REG_PATTERN_1   = 3'd1,
    REG_PATTERN_2   = 3'd2,
    REG_PATTERN_3   = 3'd3,
    REG_PATTERN_LEN = 3'd4,
    REG_CASE_EXACT  = 3'd5,
    REG_ANCHORED    = 3'd6
  } cfg_reg_t;

  // Folds A-Z to lower case unless the compare is exact.
  function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c,
                                                   input logic exact);
    logic [CHAR_W-1:0] res;
    res = c;
    if (!exact && c >= UPPER_A_CHAR && c <= UPPER_Z_CHAR) begin
      res = c | CASE_BIT;
    end
    return res;
  endfunction

endpackage

### hw/rtl/lsm_channels.sv
`timescale 1ns / 1ps

interface lsm_in_if;
  import lsm_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_byte;
  logic              first_of_file;
  modport source(output valid, char_byte, first_of_file, input ready);
  modport sink(input valid, char_byte, first_of_file, output ready);
endinterface

interface lsm_out_if;
  import lsm_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     line_matched;
  logic [LINE_NUMBER_W-1:0] line_number;
  logic [LINE_LENGTH_W-1:0] line_length;
  modport source(output valid, line_matched, line_number, line_length, input ready);
  modport sink(input valid, line_matched, line_number, line_length, output ready);
endinterface

interface lsm_cfg_if;
  import lsm_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] reg_index;
  logic [CFG_DATA_W-1:0]  wr_data;
  modport source(output valid, reg_index, wr_data, input ready);
  modport sink(input valid, reg_index, wr_data, output ready);
endinterface

### hw/rtl/line_substring_matcher.sv
`timescale 1ns / 1ps

// Channel   Direction  Payload                                   Transfer
// in_ch     sink       char_byte, first_of_file                  valid && ready
// out_ch    source     line_matched, line_number, line_length    valid && ready
// cfg_ch    sink       reg_index, wr_data                        valid && ready
//
// Every byte is scanned while it sits in the input register; a newline loads
// the output register as it leaves the input register, which it holds until
// the output register is free or being emptied.
// One byte per cycle is sustained while no newline waits for the output
// register.
// Reset is synchronous and active low; it clears configuration and line state.
// A result held by the receiver stalls only the next newline, which then holds
// the input register and with it the input channel; other bytes keep flowing.

module line_substring_matcher #(
  parameter int PATTERN_MAX      = lsm_pkg::PATTERN_MAX_DEF,
  parameter int LINE_MAX         = lsm_pkg::LINE_MAX_DEF,
  parameter int LINE_NUMBER_BITS = lsm_pkg::LINE_NUMBER_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  lsm_in_if.sink         in_ch,
  lsm_out_if.source      out_ch,
  lsm_cfg_if.sink        cfg_ch
);
  import lsm_pkg::*;

  // Width of the clamped pattern length and of an index into the pattern.
  localparam int PLEN_W = $clog2(PATTERN_MAX + 1);
  localparam int PIDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  // History of earlier kept bytes; the current byte completes the window.
  localparam int WIN_D  = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;
  // Kept-byte counter holds up to LINE_MAX-1.
  localparam int POS_W  = $clog2(LINE_MAX);
  // The line counter never needs more bits than the output field.
  localparam int NUM_W  = (LINE_NUMBER_BITS < LINE_NUMBER_W) ? LINE_NUMBER_BITS
                                                             : LINE_NUMBER_W;
  localparam int CW     = (POS_W > PLEN_W) ? POS_W : PLEN_W;
  localparam int LCW    = (POS_W > LINE_LENGTH_W) ? POS_W : LINE_LENGTH_W;

  localparam logic [POS_W-1:0] POS_LAST   = POS_W'(LINE_MAX - 1);
  localparam logic [LCW-1:0]   LENGTH_CAP = LCW'((1 << LINE_LENGTH_W) - 1);
  localparam logic [NUM_W-1:0] NUM_CAP    = {NUM_W{1'b1}};

  // ---------------------------------------------------------------------
  // Configuration registers. The port never stalls.
  // ---------------------------------------------------------------------
  logic [CHAR_W-1:0] pat_r [PATTERN_MAX];
  logic [PLEN_W-1:0] len_r;
  logic              exact_cmp_r;
  logic              anchored_r;

  logic              cfg_fire;
  logic              pat_we;
  logic              len_we;
  logic              cs_we;
  logic              anch_we;
  logic [5:0]        len_field;
  logic [PLEN_W-1:0] len_clamped;

  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid;

  always_comb begin
    pat_we  = 1'b0;
    len_we  = 1'b0;
    cs_we   = 1'b0;
    anch_we = 1'b0;
    unique case (cfg_reg_t'(cfg_ch.reg_index)) inside
      REG_PATTERN_0, REG_PATTERN_1, REG_PATTERN_2, REG_PATTERN_3: pat_we = cfg_fire;
      REG_PATTERN_LEN: len_we  = cfg_fire;
      REG_CASE_EXACT:  cs_we   = cfg_fire;
      REG_ANCHORED:    anch_we = cfg_fire;
      default: begin
        // Writes beyond the register list are dropped.
      end
    endcase
  end

  // A length beyond the pattern store acts as the full store.
  assign len_field   = cfg_ch.wr_data[5:0];
  assign len_clamped = (len_field > 6'(PATTERN_MAX)) ? PLEN_W'(PATTERN_MAX)
                                                     : PLEN_W'(len_field);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < PATTERN_MAX; j++) begin
        pat_r[j] <= '0;
      end
      len_r       <= '0;
      exact_cmp_r <= 1'b0;
      anchored_r  <= 1'b0;
    end else begin
      // Register r carries characters 8r to 8r+7, lowest byte first.
      for (int j = 0; j < PATTERN_MAX; j++) begin
        if (pat_we && cfg_ch.reg_index[1:0] == 2'(j >> 3)) begin
          pat_r[j] <= cfg_ch.wr_data[(j & 7) * CHAR_W +: CHAR_W];
        end
      end
      if (len_we) begin
        len_r <= len_clamped;
      end
      if (cs_we) begin
        exact_cmp_r <= cfg_ch.wr_data[0];
      end
      if (anch_we) begin
        anchored_r <= cfg_ch.wr_data[0];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Aligned pattern. Slot k holds the character that must sit k bytes
  // before the newest byte, already folded, so the per-byte compare needs
  // no variable shift. It is registered from the configuration; the user, not
  // the block, sees that it follows before the first byte using it is scanned.
  // ---------------------------------------------------------------------
  logic [CHAR_W-1:0]      aligned_r [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] care_r;
  logic [PIDX_W-1:0]      align_sel [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] care_nxt;

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_align
    assign care_nxt[k]  = PLEN_W'(k) < len_r;
    assign align_sel[k] = care_nxt[k] ? PIDX_W'(len_r - PLEN_W'(k) - PLEN_W'(1))
                                      : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      care_r <= '0;
    end else begin
      care_r <= care_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < PATTERN_MAX; k++) begin
      aligned_r[k] <= fold_char(pat_r[align_sel[k]], exact_cmp_r);
    end
  end

  // ---------------------------------------------------------------------
  // Input register.
  // ---------------------------------------------------------------------
  logic              s1_v_r;
  logic [CHAR_W-1:0] s1_char_r;
  logic              s1_first_r;
  logic              s1_is_nl;
  logic              s1_go;
  logic              in_fire;
  logic              out_fire;

  assign s1_is_nl     = s1_char_r == NEWLINE_CHAR;
  // A newline needs a free output register; other bytes never wait.
  assign s1_go        = s1_v_r && (!s1_is_nl || !out_ch.valid || out_ch.ready);
  assign in_ch.ready  = !s1_v_r || s1_go;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_fire     = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_char_r  <= in_ch.char_byte;
      s1_first_r <= in_ch.first_of_file;
    end
  end

  // ---------------------------------------------------------------------
  // Line state and the window scan.
  // ---------------------------------------------------------------------
  logic [CHAR_W-1:0] recent_r [WIN_D];
  logic [POS_W-1:0]  pos_r;
  logic              match_r;
  logic [NUM_W-1:0]  line_r;

  logic [POS_W-1:0]       pos_base;
  logic                   match_base;
  logic [NUM_W-1:0]       line_base;
  logic [CHAR_W-1:0]      win [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] slot_ok;
  logic [CW-1:0]          pos_ext;
  logic [CW-1:0]          len_m1_ext;
  logic                   len_nz;
  logic                   place_ok;
  logic                   keep;
  logic                   hit;

  // The first byte of a file drops any partial line before it is handled.
  assign pos_base   = s1_first_r ? '0 : pos_r;
  assign match_base = s1_first_r ? 1'b0 : match_r;
  assign line_base  = s1_first_r ? NUM_W'(1) : line_r;

  assign win[0] = s1_char_r;
  for (genvar k = 1; k < PATTERN_MAX; k++) begin : g_win
    assign win[k] = recent_r[k-1];
  end

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cmp
    assign slot_ok[k] = !care_r[k] || fold_char(win[k], exact_cmp_r) == aligned_r[k];
  end

  // The whole pattern must lie inside the kept part of this line, and in
  // anchored mode it must end exactly where it would if it began the line.
  assign len_nz     = len_r != '0;
  assign pos_ext    = CW'(pos_base);
  assign len_m1_ext = CW'(len_r) - CW'(1);
  assign place_ok   = len_nz && pos_ext >= len_m1_ext &&
                      (!anchored_r || pos_ext == len_m1_ext);
  assign keep       = pos_base < POS_LAST;
  assign hit        = place_ok && (&slot_ok);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      match_r <= 1'b0;
      line_r  <= NUM_W'(1);
    end else if (s1_go) begin
      if (s1_is_nl) begin
        pos_r   <= '0;
        match_r <= 1'b0;
        line_r  <= (line_base != NUM_CAP) ? line_base + NUM_W'(1) : line_base;
      end else begin
        pos_r   <= keep ? pos_base + POS_W'(1) : pos_base;
        match_r <= match_base || (keep && hit);
        line_r  <= line_base;
      end
    end
  end

  // The history only ever holds bytes of the current line where it is read,
  // so it needs no reset.
  always_ff @(posedge clk) begin
    if (s1_go && !s1_is_nl && keep) begin
      recent_r[0] <= s1_char_r;
      for (int i = 1; i < WIN_D; i++) begin
        recent_r[i] <= recent_r[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------
  logic                     out_v_r;
  logic                     out_matched_r;
  logic [LINE_NUMBER_W-1:0] out_number_r;
  logic [LINE_LENGTH_W-1:0] out_length_r;
  logic [LCW-1:0]           kept_ext;
  logic                     res_load;

  assign res_load = s1_go && s1_is_nl;
  assign kept_ext = LCW'(pos_base);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (res_load) begin
      out_v_r <= 1'b1;
    end else if (out_fire) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_matched_r <= match_base || !len_nz;
      out_number_r  <= LINE_NUMBER_W'(line_base);
      out_length_r  <= LINE_LENGTH_W'((kept_ext > LENGTH_CAP) ? LENGTH_CAP : kept_ext);
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.line_matched = out_matched_r;
  assign out_ch.line_number  = out_number_r;
  assign out_ch.line_length  = out_length_r;

endmodule

### test/tb.sv
`timescale 1ns / 1ps

import lsm_pkg::*;

// One finished line as the matcher reports it.
typedef struct packed {
  logic                     matched;
  logic [LINE_NUMBER_W-1:0] number;
  logic [LINE_LENGTH_W-1:0] length;
} line_result_t;

// Search settings as software would load them.
typedef struct packed {
  logic [3:0][CFG_DATA_W-1:0] pat;
  logic [5:0]                 len;
  logic                       cs;
  logic                       anch;
} search_cfg_t;

localparam int WINDOW_DEPTH = PATTERN_MAX_DEF - 1;
localparam int KEPT_MAX     = LINE_MAX_DEF - 1;
localparam int LENGTH_CAP   = (1 << LINE_LENGTH_W) - 1;
localparam int unsigned LINE_NUMBER_LIMIT =
  (LINE_NUMBER_BITS_DEF >= 20) ? 20'hFFFFF : (1 << LINE_NUMBER_BITS_DEF) - 1;

// Tracks the search state of the matcher and the line results still owed.
class line_match_scoreboard;
  logic [CFG_DATA_W-1:0]    pat_regs [4];
  logic [5:0]               pat_len;
  logic                     exact_cmp;
  logic                     anchored;
  logic [CHAR_W-1:0]        recent [WINDOW_DEPTH];
  int unsigned              kept_count;
  bit                       seen;
  logic [LINE_NUMBER_W-1:0] line_no;
  line_result_t             pending_lines [$];
  int unsigned              error_count;

  function new();
    foreach (pat_regs[i]) pat_regs[i] = '0;
    foreach (recent[i]) recent[i] = '0;
    pat_len     = '0;
    exact_cmp   = 1'b0;
    anchored    = 1'b0;
    kept_count  = 0;
    seen        = 1'b0;
    line_no     = 1;
    error_count = 0;
  endfunction

  function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_PATTERN_0, REG_PATTERN_1, REG_PATTERN_2, REG_PATTERN_3: begin
        pat_regs[idx] = data;
      end
      REG_PATTERN_LEN: pat_len = data[5:0];
      REG_CASE_EXACT:  exact_cmp = data[0];
      REG_ANCHORED:    anchored = data[0];
      default: ;
    endcase
  endfunction

  function int used_len();
    return (pat_len > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : int'(pat_len);
  endfunction

  function logic [CHAR_W-1:0] pat_char(int idx);
    return pat_regs[idx >> 3][(idx & 7) * 8 +: 8];
  endfunction

  function logic [CHAR_W-1:0] lower(logic [CHAR_W-1:0] c);
    if (!exact_cmp && c >= UPPER_A_CHAR && c <= UPPER_Z_CHAR) return c + CASE_BIT;
    return c;
  endfunction

  function void note_byte(logic [CHAR_W-1:0] b, logic fof);
    int  used;
    bit  hit;
    used = used_len();
    hit  = 1'b0;
    if (fof) begin
      kept_count = 0;
      seen       = 1'b0;
      line_no    = 1;
    end
    if (b == NEWLINE_CHAR) begin
      pending_lines.push_back({seen || used == 0, line_no,
                               LINE_LENGTH_W'((kept_count > LENGTH_CAP) ? LENGTH_CAP
                                                                        : kept_count)});
      if (line_no < LINE_NUMBER_LIMIT) line_no++;
      kept_count = 0;
      seen       = 1'b0;
    end else if (kept_count < KEPT_MAX) begin
      if (used > 0 && kept_count >= used - 1 && (!anchored || kept_count == used - 1)) begin
        hit = lower(b) == lower(pat_char(used - 1));
        for (int k = 1; k < used; k++) begin
          if (lower(recent[k - 1]) != lower(pat_char(used - 1 - k))) hit = 1'b0;
        end
      end
      if (hit) seen = 1'b1;
      for (int i = WINDOW_DEPTH - 1; i > 0; i--) recent[i] = recent[i - 1];
      recent[0] = b;
      kept_count++;
    end
  endfunction

  function void note_error(string msg);
    if (error_count < 10) $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endfunction

  function void check_line(logic m, logic [LINE_NUMBER_W-1:0] n, logic [LINE_LENGTH_W-1:0] l);
    line_result_t want;
    if (pending_lines.size() == 0) begin
      note_error($sformatf("unexpected line result: matched %0d line %0d length %0d",
                           m, n, l));
      return;
    end
    want = pending_lines.pop_front();
    if (m !== want.matched || n !== want.number || l !== want.length) begin
      note_error($sformatf({"line result: expected matched %0d line %0d length %0d, ",
                            "got matched %0d line %0d length %0d"},
                           want.matched, want.number, want.length, m, n, l));
    end
  endfunction
endclass

module tb;

  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 8;
  localparam int SETTLE_CYCLES   = 4;
  localparam int TAIL_CYCLES     = 10;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 250;

  logic clk = 1'b0;
  logic rst_n;

  lsm_in_if  in_ch();
  lsm_out_if out_ch();
  lsm_cfg_if cfg_ch();

  line_substring_matcher u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  line_match_scoreboard sb = new();

  // Idle rates in percent for the byte sender and the result receiver.
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  int unsigned quiet_cycles = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  // The receiver stalls at random; with a zero rate it is always ready.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // All three channels are observed at the clock edge, so the values seen are
  // the ones that were present when the transfer took place.
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (in_ch.valid && in_ch.ready) sb.note_byte(in_ch.char_byte, in_ch.first_of_file);
      if (out_ch.valid && out_ch.ready) begin
        sb.check_line(out_ch.line_matched, out_ch.line_number, out_ch.line_length);
      end
      if (cfg_ch.valid && cfg_ch.ready) sb.write_reg(cfg_reg_t'(cfg_ch.reg_index), cfg_ch.wr_data);
    end
  end

  // Watchdog: any transfer on any channel counts as progress.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  // Any byte except the newline, so that random text does not end lines.
  function automatic logic [CHAR_W-1:0] any_text_byte();
    logic [CHAR_W-1:0] b;
    b = CHAR_W'($urandom_range(0, 254));
    if (b >= NEWLINE_CHAR) b++;
    return b;
  endfunction

  // A pattern character, now and then with its letter case flipped; in an
  // exact search the flip turns an occurrence into a near miss.
  function automatic logic [CHAR_W-1:0] pattern_variant(int idx);
    logic [CHAR_W-1:0] c;
    c = sb.pat_char(idx);
    if ((c & ~CASE_BIT) >= UPPER_A_CHAR && (c & ~CASE_BIT) <= UPPER_Z_CHAR &&
        $urandom_range(0, 3) == 0) begin
      c = c ^ CASE_BIT;
    end
    return c;
  endfunction

  // Filler text leans on the pattern's own characters so that partial and
  // overlapping occurrences are common.
  function automatic logic [CHAR_W-1:0] filler_byte();
    int used;
    logic [CHAR_W-1:0] b;
    used = sb.used_len();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: b = (used > 0) ? pattern_variant($urandom_range(0, used - 1)) : "a";
      4: b = "a";
      5: b = "A";
      6: b = "b";
      7: b = "B";
      default: b = any_text_byte();
    endcase
    return b;
  endfunction

  // Settings for one random phase. The length walks through its extremes
  // (one, the full window, empty, overlong) and case/anchor modes alternate.
  function automatic search_cfg_t make_config(int phase);
    search_cfg_t c;
    int used;
    for (int r = 0; r < 4; r++) c.pat[r] = {$urandom, $urandom};
    case (phase)
      0: c.len = 6'd1;
      1: c.len = 6'd32;
      2: c.len = 6'd0;
      3: c.len = 6'($urandom_range(33, 63));
      4: c.len = 6'd31;
      default: c.len = 6'($urandom_range(2, 8));
    endcase
    c.cs   = phase[0];
    c.anch = phase[1];
    used = (c.len > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : int'(c.len);
    for (int i = 0; i < used; i++) begin
      case ($urandom_range(0, 5))
        0: c.pat[i >> 3][(i & 7) * 8 +: 8] = "a";
        1: c.pat[i >> 3][(i & 7) * 8 +: 8] = "b";
        2: c.pat[i >> 3][(i & 7) * 8 +: 8] = "A";
        3: c.pat[i >> 3][(i & 7) * 8 +: 8] = "B";
        4: c.pat[i >> 3][(i & 7) * 8 +: 8] = "c";
        default: c.pat[i >> 3][(i & 7) * 8 +: 8] = any_text_byte();
      endcase
    end
    return c;
  endfunction

  // Offers one byte, idling first at the sender's rate, and returns after the
  // transfer with valid still high.
  task automatic send_byte(input logic [CHAR_W-1:0] b, input logic fof);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.char_byte     <= b;
    in_ch.first_of_file <= fof;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  // Drops valid and waits for a clock edge, so that a following drive of valid
  // never lands in the same time step.
  task automatic hold_input();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_for_results();
    while (sb.pending_lines.size() != 0) @(posedge clk);
  endtask

  // Loads all seven registers back to back once the matcher has gone quiet.
  // Bytes without a result may still sit in the pipeline after the last
  // result, hence the extra settle cycles. Unused upper data bits are random.
  task automatic reconfigure(input search_cfg_t c);
    logic [CFG_DATA_W-1:0] vals [7];
    logic [31:0]           rnd_hi;
    logic [31:0]           rnd_lo;
    hold_input();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    for (int r = 0; r < 4; r++) vals[r] = c.pat[r];
    rnd_hi = $urandom;
    rnd_lo = $urandom;
    vals[REG_PATTERN_LEN] = {rnd_hi, rnd_lo[25:0], c.len};
    rnd_hi = $urandom;
    rnd_lo = $urandom;
    vals[REG_CASE_EXACT]  = {rnd_hi, rnd_lo[30:0], c.cs};
    rnd_hi = $urandom;
    rnd_lo = $urandom;
    vals[REG_ANCHORED]    = {rnd_hi, rnd_lo[30:0], c.anch};
    for (int i = 0; i < 7; i++) begin
      cfg_ch.valid     <= 1'b1;
      cfg_ch.reg_index <= cfg_reg_t'(i);
      cfg_ch.wr_data   <= vals[i];
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // One random line. Most lines are well formed, about half of them with the
  // pattern planted somewhere (at the start in anchored mode). Some are pure
  // noise with stray newlines and file starts, and some stop without a
  // newline, after which the next byte opens a new file.
  task automatic send_random_line(inout bit new_file, inout int sent);
    int used;
    int kind;
    int body;
    int pos;
    bit embed;
    logic [CHAR_W-1:0] b;
    logic fof;
    used = sb.used_len();
    kind = $urandom_range(0, 11);
    if (kind == 0) begin
      body = $urandom_range(1, 12);
      for (int i = 0; i < body; i++) begin
        fof = new_file || ($urandom_range(0, 7) == 0);
        new_file = 1'b0;
        send_byte(CHAR_W'($urandom_range(0, 255)), fof);
        sent++;
      end
      return;
    end
    embed = (used > 0) && (kind <= 6);
    body  = $urandom_range(0, 10) + (embed ? used : 0);
    if (!embed || sb.anchored || $urandom_range(0, 2) == 0) pos = 0;
    else pos = $urandom_range(0, body - used);
    for (int i = 0; i < body; i++) begin
      if (embed && i >= pos && i < pos + used) b = pattern_variant(i - pos);
      else b = filler_byte();
      fof = new_file || (i == 0 && $urandom_range(0, 39) == 0);
      new_file = 1'b0;
      send_byte(b, fof);
      sent++;
    end
    if (kind == 11) begin
      new_file = 1'b1;
    end else begin
      send_byte(NEWLINE_CHAR, new_file);
      new_file = 1'b0;
      sent++;
    end
  endtask

  // A line longer than the matcher keeps. The pattern either ends on the last
  // kept byte, or on the first dropped one, where it must not count.
  task automatic send_long_line(input bit past_cap);
    int used;
    int body;
    int pos;
    used = sb.used_len();
    body = LINE_MAX_DEF + $urandom_range(0, 60);
    pos  = past_cap ? LINE_MAX_DEF - used : KEPT_MAX - used;
    for (int i = 0; i < body; i++) begin
      if (used > 0 && i >= pos && i < pos + used) send_byte(sb.pat_char(i - pos), 1'b0);
      else send_byte(filler_byte(), 1'b0);
    end
    send_byte(NEWLINE_CHAR, 1'b0);
  endtask

  initial begin
    search_cfg_t c;
    int sent;
    bit new_file;
    bit paused;

    in_ch.valid         <= 1'b0;
    in_ch.char_byte     <= '0;
    in_ch.first_of_file <= 1'b0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.reg_index    <= '0;
    cfg_ch.wr_data      <= '0;
    rst_n               <= 1'b0;
    tx_idle_pct = 18;
    rx_idle_pct = 47;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Out of reset the pattern is empty, so every line matches,
    // an empty one too; the extreme byte values go through as text.
    send_byte(NEWLINE_CHAR, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(NEWLINE_CHAR, 1'b0);
    // A line cut off by the start of a new file yields nothing, and the
    // numbering starts again at one.
    send_text("ab");
    send_byte("c", 1'b1);
    send_byte(NEWLINE_CHAR, 1'b0);

    // Anchored, case-folded search for "aB" (character 0 in the low byte).
    c     = '0;
    c.pat[0] = 64'h4261;
    c.len  = 6'd2;
    c.cs   = 1'b0;
    c.anch = 1'b1;
    reconfigure(c);
    send_text("ab\n");
    send_text("xab\n");
    send_text("AB\n");

    // Same pattern, exact case, anywhere in the line.
    c.cs   = 1'b1;
    c.anch = 1'b0;
    reconfigure(c);
    send_text("xaB\n");
    send_text("ab\n");

    // Random part. Idle rates change with the phase: sender light and
    // receiver heavy, then the reverse, then no idling at all.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase < 3) begin
        tx_idle_pct = 18;
        rx_idle_pct = 47;
      end else if (phase < 6) begin
        tx_idle_pct = 47;
        rx_idle_pct = 18;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      reconfigure(make_config(phase));
      sent     = 0;
      new_file = 1'b0;
      paused   = 1'b0;
      while (sent < ITEMS_PER_PHASE) begin
        // Halfway through, the sender waits until every owed result is out.
        if (!paused && sent >= ITEMS_PER_PHASE / 2) begin
          hold_input();
          wait_for_results();
          paused = 1'b1;
          if (phase == 1) send_long_line(1'b0);
          if (phase == 4) send_long_line(1'b1);
        end
        send_random_line(new_file, sent);
      end
    end

    hold_input();
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.error_count == 0 && sb.pending_lines.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
